@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files of the block.
// Each macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define TKI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true at a sampled edge.
`define TKI_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/tki_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tki_pkg;

	localparam int POS_W   = 16;
	localparam int SCORE_W = 32;
	localparam int KEEP_W  = 5;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd4;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      is_last;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]          position;
		logic signed [SCORE_W-1:0] kept_score;
		logic                      too_short;
		logic                      last_result;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture item, latch keep count, clear slot address
		logic scan_rd;   // read slot for the minimum search, advance address
		logic emit_rd;   // read slot for output, advance address
		logic wr_fill;   // write item into next free slot
		logic wr_repl;   // overwrite the minimum slot with the item
		logic cnt_inc;   // count the item
		logic cnt_clr;   // end of list: restart count
		logic addr_clr;  // rewind slot address
		logic err;       // issue the too-short result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_range;  // item count below the list limit
		logic below_k;   // item count below the keep count
		logic addr_end;  // slot address at the last kept slot
		logic better;    // item strictly above the smallest kept score
		logic last;      // item closes the list
	} sts_t;

endpackage
`default_nettype wire

@@ sv/top_k_index_selection.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Streaming top-k selection: keeps the list positions of the keep_count largest scores.
// Items are taken one at a time: a fill item is written straight into its slot; a compare
// item scans the k kept slots for the minimum, one slot per cycle (k = keep count), and
// replaces it when strictly greater. A closing item's results then strobe one per cycle,
// busy held while the slots are read; a list shorter than k gives a single error result.
// Reset (arst_n low, asynchronous) clears the item count, keep_count returns to 4; results never stall.
module top_k_index_selection #(
	parameter int MAX_KEEP  = 16,
	parameter int MAX_ITEMS = 65536
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// item channel: a transaction is taken when start is high and busy is low
	input  wire logic                        start,
	output logic                             busy,
	input  wire tki_pkg::item_t              item,
	// result channel: one transaction per strobe cycle
	output logic                             strobe,
	output tki_pkg::result_t                 result,
	// keep_count register write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tki_pkg::KEEP_W-1:0]  cfg_data
);

	tki_pkg::cmd_t cmd;
	tki_pkg::sts_t sts;

	// Take register writes only between items.
	assign cfg_ready = ~busy;

	// Sequence each item: fill or scan for the minimum, replace, then emit at list end.
	tki_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Slot RAM, item counter, minimum tracker and result formatting.
	tki_datapath #(
		.MAX_KEEP  (MAX_KEEP),
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result),
		.strobe   (strobe)
	);

endmodule
`default_nettype wire

@@ sv/tki_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tki_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                     wr_data,
	input  wire logic                                 rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ sv/tki_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tki_datapath #(
	parameter int MAX_KEEP  = 16,
	parameter int MAX_ITEMS = 65536
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tki_pkg::item_t                  item,
	input  wire logic                            cfg_we,
	input  wire logic [tki_pkg::KEEP_W-1:0]      cfg_data,
	input  wire tki_pkg::cmd_t                   cmd,
	output tki_pkg::sts_t                        sts,
	output tki_pkg::result_t                     result,
	output logic                                 strobe
);

	localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int KW = $clog2(MAX_KEEP + 1);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int DW = tki_pkg::POS_W + tki_pkg::SCORE_W;

	logic [tki_pkg::KEEP_W-1:0]          keep_q;
	logic signed [tki_pkg::SCORE_W-1:0]  score_q;
	logic                                last_q;
	logic [KW-1:0]                       k_q;
	logic [AW-1:0]                       kl_q;
	logic [CW-1:0]                       items_q;
	logic [AW-1:0]                       addr_q;
	logic signed [tki_pkg::SCORE_W-1:0]  min_score_q;
	logic [AW-1:0]                       min_idx_q;
	logic                                scan_v_s1;
	logic [AW-1:0]                       scan_a_s1;
	logic                                emit_v_s1;
	logic                                emit_last_s1;
	logic                                err_s1;

	logic [31:0]                         keep32;
	logic [31:0]                         keff;
	logic                                wr_en;
	logic [AW-1:0]                       wr_addr;
	logic [DW-1:0]                       wr_data;
	logic [DW-1:0]                       rd_data;
	logic [tki_pkg::POS_W-1:0]           rd_pos;
	logic signed [tki_pkg::SCORE_W-1:0]  rd_score;

	// Clamp the keep count into 1..MAX_KEEP.
	always_comb begin
		keep32 = 32'(keep_q);
		if (keep32 == 32'd0) begin
			keff = 32'd1;
		end else if (keep32 > 32'(MAX_KEEP)) begin
			keff = 32'(MAX_KEEP);
		end else begin
			keff = keep32;
		end
	end

	assign wr_en   = cmd.wr_fill | cmd.wr_repl;
	assign wr_addr = cmd.wr_fill ? AW'(32'(items_q)) : min_idx_q;
	assign wr_data = {tki_pkg::POS_W'(32'(items_q)), score_q};

	tki_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_KEEP)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.scan_rd | cmd.emit_rd),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	assign rd_pos   = rd_data[DW-1 -: tki_pkg::POS_W];
	assign rd_score = rd_data[tki_pkg::SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q       <= tki_pkg::KEEP_RESET;
			items_q      <= '0;
			addr_q       <= '0;
			scan_v_s1    <= 1'b0;
			emit_v_s1    <= 1'b0;
			err_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_data;
			end
			if (cmd.cnt_clr) begin
				items_q <= '0;
			end else if (cmd.cnt_inc) begin
				items_q <= items_q + CW'(1);
			end
			if (cmd.load || cmd.addr_clr) begin
				addr_q <= '0;
			end else if (cmd.scan_rd || cmd.emit_rd) begin
				addr_q <= addr_q + AW'(1);
			end
			scan_v_s1 <= cmd.scan_rd;
			emit_v_s1 <= cmd.emit_rd;
			err_s1    <= cmd.err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			score_q <= item.score;
			last_q  <= item.is_last;
			k_q     <= KW'(keff);
			kl_q    <= AW'(keff - 32'd1);
		end
		scan_a_s1    <= addr_q;
		emit_last_s1 <= (addr_q == kl_q);
		// Slot zero opens the search; later slots win only when strictly smaller.
		if (scan_v_s1 && (scan_a_s1 == '0 || rd_score < min_score_q)) begin
			min_score_q <= rd_score;
			min_idx_q   <= scan_a_s1;
		end
	end

	assign sts.in_range = (32'(items_q) < 32'(MAX_ITEMS));
	assign sts.below_k  = (32'(items_q) < 32'(k_q));
	assign sts.addr_end = (addr_q == kl_q);
	assign sts.better   = (min_score_q < score_q);
	assign sts.last     = last_q;

	always_comb begin
		if (err_s1) begin
			result.position    = '0;
			result.kept_score  = '0;
			result.too_short   = 1'b1;
			result.last_result = 1'b1;
		end else begin
			result.position    = rd_pos;
			result.kept_score  = rd_score;
			result.too_short   = 1'b0;
			result.last_result = emit_last_s1;
		end
	end

	assign strobe = emit_v_s1 | err_s1;

	`TKI_NEVER(a_one_result_kind, emit_v_s1 && err_s1, "emit and error results collide")
	`TKI_NEVER(a_one_writer, cmd.wr_fill && cmd.wr_repl, "fill and replace write together")
	`TKI_ASSERT(a_scan_in_k, cmd.scan_rd |-> (addr_q <= kl_q), "slot read beyond keep count")

endmodule
`default_nettype wire

@@ sv/tki_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tki_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire tki_pkg::sts_t  sts,
	output tki_pkg::cmd_t       cmd,
	output logic                busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_REPL,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!sts.in_range) begin
					state_d = ST_CHECK;
				end else if (sts.below_k) begin
					cmd.wr_fill = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = ST_CHECK;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = sts.addr_end ? ST_SCAN_WAIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.addr_end) begin
					state_d = ST_SCAN_WAIT;
				end
			end
			ST_SCAN_WAIT: begin
				state_d = ST_REPL;
			end
			ST_REPL: begin
				cmd.wr_repl = sts.better;
				cmd.cnt_inc = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (sts.below_k) begin
					cmd.err     = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.addr_clr = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_rd = 1'b1;
				if (sts.addr_end) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TKI_ASSERT(a_load_from_idle, cmd.load |=> (state_q == ST_DISPATCH), "load did not dispatch")

endmodule
`default_nettype wire

@@ tb/tb_top_k_index_selection.sv @@
`timescale 1ns / 1ps
module tb_top_k_index_selection;

	localparam int POS_W         = tki_pkg::POS_W;
	localparam int SCORE_W       = tki_pkg::SCORE_W;
	localparam int KEEP_W        = tki_pkg::KEEP_W;
	localparam int SLOT_COUNT    = 16;       // slot depth of the block as built
	localparam int LIST_LIMIT    = 65536;    // items counted per list, the rest are dropped
	localparam int SETTLE_CYCLES = 24;       // covers a pending compare item's slot scan, k <= 16
	localparam int CYCLE_LIMIT   = 200000;   // aborts a hung run of ~450 items, with margin
	localparam int RANDOM_ITEMS  = 350;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	tki_pkg::item_t    item      = '0;
	logic              strobe;
	tki_pkg::result_t  result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [KEEP_W-1:0] cfg_data  = '0;

	top_k_index_selection dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block: keep count register, kept slots and the item count.
	logic [KEEP_W-1:0]         keep_reg = tki_pkg::KEEP_RESET;
	logic [POS_W-1:0]          slot_pos [SLOT_COUNT];
	logic signed [SCORE_W-1:0] slot_sc  [SLOT_COUNT];
	int unsigned               list_count = 0;

	// Kept positions still owed by the block, oldest first.
	tki_pkg::result_t kept_q [$];
	int               errors  = 0;
	int               max_gap = 6;
	int unsigned      cycles  = 0;

	// Clamp the register the way the block does: 0 keeps one, above the depth keeps all.
	function automatic int keep_effective();
		if (keep_reg == 0)
			return 1;
		if (keep_reg > SLOT_COUNT)
			return SLOT_COUNT;
		return int'(keep_reg);
	endfunction

	// Fold one accepted item into the kept set; on the closing item queue what must come out.
	function automatic void select_top_k(input tki_pkg::item_t it);
		int                        k;
		int                        m;
		logic signed [SCORE_W-1:0] sc;
		tki_pkg::result_t          r;
		k  = keep_effective();
		sc = it.score;
		if (list_count < LIST_LIMIT) begin
			if (list_count < k) begin
				slot_pos[list_count] = POS_W'(list_count);
				slot_sc[list_count]  = sc;
			end else begin
				// first slot holding the minimum wins ties
				m = 0;
				for (int i = 1; i < k; i++)
					if (slot_sc[i] < slot_sc[m])
						m = i;
				// replace only on a strictly greater score
				if (sc > slot_sc[m]) begin
					slot_pos[m] = POS_W'(list_count);
					slot_sc[m]  = sc;
				end
			end
			list_count++;
		end
		if (!it.is_last)
			return;
		if (list_count < k) begin
			r = '{position: '0, kept_score: '0, too_short: 1'b1, last_result: 1'b1};
			kept_q.insert(kept_q.size(), r);
		end else begin
			for (int i = 0; i < k; i++) begin
				r = '{position: slot_pos[i], kept_score: slot_sc[i], too_short: 1'b0,
				      last_result: (i == k - 1)};
				kept_q.insert(kept_q.size(), r);
			end
		end
		list_count = 0;
	endfunction

	// Check each strobed result against the oldest expectation, then track new
	// transactions: register writes first, since they never share an edge with an item.
	always @(posedge clk) begin : scoreboard
		tki_pkg::result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (kept_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result pos=%0d score=%0d short=%b last=%b",
					         $time, result.position, result.kept_score,
					         result.too_short, result.last_result);
				end else begin
					want = kept_q.pop_front();
					if (result.position !== want.position ||
					    result.kept_score !== want.kept_score ||
					    result.too_short !== want.too_short ||
					    result.last_result !== want.last_result) begin
						errors++;
						$display("%0t: mismatch expected pos=%0d score=%0d short=%b last=%b",
						         $time, want.position, want.kept_score,
						         want.too_short, want.last_result);
						$display("%0t:          actual   pos=%0d score=%0d short=%b last=%b",
						         $time, result.position, result.kept_score,
						         result.too_short, result.last_result);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				keep_reg = cfg_data;
			if (start && !busy)
				select_top_k(item);
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one item after a random gap and hold it until the block takes it.
	// Leave start high on return so back-to-back items need no second assignment.
	task automatic send_item(input logic signed [SCORE_W-1:0] sc, input logic last);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item  <= '{score: sc, is_last: last};
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start, wait for every owed result, then let a pending compare item finish.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write keep_count only once the block has gone quiet.
	task automatic write_keep(input logic [KEEP_W-1:0] value);
		wait_idle();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly full-range scores, some from a narrow band to force ties, a few extremes.
	function automatic logic signed [SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2, 3, 4: return SCORE_W'($urandom_range(0, 7)) - 32'sd4;
			default: return $urandom();
		endcase
	endfunction

	// Mostly small keep counts; sometimes the full depth or the out-of-range codes.
	function automatic logic [KEEP_W-1:0] pick_keep();
		case ($urandom_range(0, 9))
			0:       return KEEP_W'(0);
			1:       return KEEP_W'($urandom_range(SLOT_COUNT + 1, 31));
			2, 3:    return KEEP_W'($urandom_range(9, SLOT_COUNT));
			default: return KEEP_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Reset value of keep_count (4): fill with the extremes, then replace the minimum,
	// then a score equal to the minimum that must not replace it.
	task automatic test_default_keep();
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh0000_0000, 1'b0);
		send_item(32'shffff_ffff, 1'b0);
		send_item(32'sh0000_0001, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh0000_0000, 1'b1);
		wait_idle();
	endtask

	// Lists shorter than the keep count give the single error result.
	task automatic test_short_lists();
		send_item(32'sh1234_5678, 1'b0);
		send_item(-32'sd7, 1'b1);
		send_item(32'sh7fff_ffff, 1'b1);
		wait_idle();
	endtask

	// Keep count 0 acts as one slot; 17 clamps to the full depth.
	task automatic test_keep_extremes();
		write_keep(KEEP_W'(0));
		send_item(32'sd5, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(32'sh8000_0000, 1'b1);
		write_keep(KEEP_W'(SLOT_COUNT + 1));
		for (int i = 0; i < SLOT_COUNT + 1; i++)
			send_item(pick_score(), i == SLOT_COUNT);
		wait_idle();
	endtask

	// Change keep_count inside a list. Items sent while the count is raised only fill
	// slots, and it is lowered before any compare, so no empty slot is ever read.
	task automatic test_keep_change_midlist();
		write_keep(KEEP_W'(8));
		for (int i = 0; i < 10; i++)
			send_item(pick_score(), 1'b0);
		write_keep(KEEP_W'(SLOT_COUNT));
		for (int i = 0; i < 3; i++)
			send_item(pick_score(), 1'b0);
		write_keep(KEEP_W'(5));
		send_item(pick_score(), 1'b0);
		send_item(pick_score(), 1'b1);
		wait_idle();
	endtask

	// Random well-formed lists, a few of them short, with keep changes between lists.
	task automatic test_random_lists();
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				write_keep(pick_keep());
			k = keep_effective();
			if ($urandom_range(0, 7) == 0)
				len = (k > 1) ? $urandom_range(1, k - 1) : 1;
			else
				len = k + $urandom_range(0, 24);
			// some lists go back to back with no sender gaps
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
			for (int i = 0; i < len; i++)
				send_item(pick_score(), i == len - 1);
			sent += len;
			// hold off now and then until everything owed has come out
			if ($urandom_range(0, 9) == 0)
				wait_idle();
		end
		max_gap = 6;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_keep();
		test_short_lists();
		test_keep_extremes();
		test_keep_change_midlist();
		test_random_lists();
		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ top_k_index_selection.f @@
+incdir+sv
sv/tki_pkg.sv
sv/tki_ram.sv
sv/tki_datapath.sv
sv/tki_ctrl.sv
sv/top_k_index_selection.sv
tb/tb_top_k_index_selection.sv
